>>> rtl/lebm_pkg.sv
`timescale 1ns / 1ps

package lebm_pkg;

    // Bytes held by the store.
    localparam int CAP_BYTES = 65536;

    localparam int ADDR_W   = $clog2(CAP_BYTES);
    localparam int ROW_W    = ADDR_W - 2;
    localparam int NUM_ROWS = CAP_BYTES / 4;
    localparam int SIZE_W   = (ADDR_W + 1 > 18) ? ADDR_W + 1 : 18;
    localparam int SIZE_RESET = (CAP_BYTES < 65536) ? CAP_BYTES : 65536;

    localparam int CFG_W  = 17;
    localparam int DATA_W = 32;

    localparam logic [7:0] FILL_BYTE = 8'hA5;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;

endpackage

>>> rtl/lebm_bank.sv
`timescale 1ns / 1ps

module lebm_bank
    import lebm_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [ROW_W-1:0] row,
    input  logic [7:0]       wdata,
    output logic [7:0]       rdata
);

    logic [7:0] mem [NUM_ROWS];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[row] <= wdata;
            end
            rdata_reg <= mem[row];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/little_endian_byte_memory_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// in        in_valid/in_ready    opcode, access_size, sign_extend, address, write_data
// out       out_valid/out_ready  read_data, out_of_range
// cfg       cfg_we               cfg_wdata (size in use)
//
// One request per cycle while in_ready is high: the four byte banks are accessed in the accept cycle,
// read data comes back in the next cycle and is assembled into the output register.
// A request passes the read stage register and then the output register before out_valid.
// After reset the banks are filled with 0xA5, one row of all four banks a cycle, with in_ready
// low until all NUM_ROWS rows (16384 at the default capacity) are written.
// A stalled output holds the request in the read stage, then blocks in_ready.

module little_endian_byte_memory_unit
    import lebm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    input  logic [1:0]        access_size,
    input  logic              sign_extend,
    input  logic [DATA_W-1:0] address,
    input  logic [DATA_W-1:0] write_data,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] read_data,
    output logic              out_of_range,

    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    typedef struct packed {
        logic       is_read;
        logic       sext;
        logic [1:0] asize;
        logic [1:0] offset;
        logic [3:0] take;   // byte lanes that are accessed and in range
        logic       bad;
    } meta_t;

    logic              clearing_reg;
    logic [ROW_W-1:0]  clr_row_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_next;
    logic [SIZE_W-1:0] cfg_round;

    logic              pipe_valid_reg;
    meta_t             pipe_reg;
    meta_t             meta_next;
    logic              pipe_adv;

    logic              out_valid_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic              oor_reg;
    logic [DATA_W-1:0] rd_next;

    logic              accept;
    logic [DATA_W-1:0] lane_addr [4];
    logic [3:0]        lane_act;
    logic [3:0]        lane_in;

    logic              bank_en   [4];
    logic              bank_we   [4];
    logic [ROW_W-1:0]  bank_row  [4];
    logic [7:0]        bank_wdat [4];
    logic [7:0]        bank_q    [4];

    // ---------------- size register ----------------
    always_comb
    begin
        cfg_round = (SIZE_W'(cfg_wdata) + SIZE_W'(15)) & ~SIZE_W'(15);
        if (cfg_round > SIZE_W'(CAP_BYTES))
        begin
            size_next = SIZE_W'(CAP_BYTES);
        end
        else
        begin
            size_next = cfg_round;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(SIZE_RESET);
        end
        else if (cfg_we)
        begin
            size_reg <= size_next;
        end
    end

    // ---------------- fill after reset ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_row_reg <= clr_row_reg + ROW_W'(1);
            if (clr_row_reg == ROW_W'(NUM_ROWS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // ---------------- flow control ----------------
    assign pipe_adv = pipe_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clearing_reg && (!pipe_valid_reg || pipe_adv);
    assign accept   = in_valid && in_ready;

    // ---------------- byte lanes ----------------
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            lane_addr[k] = address + DATA_W'(k);
            lane_in[k]   = lane_addr[k] < DATA_W'(size_reg);
        end
        lane_act[0] = 1'b1;
        lane_act[1] = (access_size != SZ_BYTE);
        lane_act[2] = (access_size != SZ_BYTE) && (access_size != SZ_HALF);
        lane_act[3] = lane_act[2];
    end

    always_comb
    begin
        meta_next.is_read = (opcode == OP_READ);
        meta_next.sext    = sign_extend;
        meta_next.asize   = access_size;
        meta_next.offset  = address[1:0];
        meta_next.take    = lane_act & lane_in;
        meta_next.bad     = |(lane_act & ~lane_in);
    end

    // bank b serves lane (b - offset) mod 4
    always_comb
    begin
        logic [1:0] k;
        for (int b = 0; b < 4; b++)
        begin
            k = 2'(b) - address[1:0];
            if (clearing_reg)
            begin
                bank_en[b]   = 1'b1;
                bank_we[b]   = 1'b1;
                bank_row[b]  = clr_row_reg;
                bank_wdat[b] = FILL_BYTE;
            end
            else
            begin
                bank_en[b]   = accept && lane_act[k] && lane_in[k];
                bank_we[b]   = (opcode == OP_WRITE);
                bank_row[b]  = lane_addr[k][ADDR_W-1:2];
                bank_wdat[b] = write_data[8*k +: 8];
            end
        end
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        lebm_bank u_bank (
            .clk   (clk),
            .en    (bank_en[b]),
            .we    (bank_we[b]),
            .row   (bank_row[b]),
            .wdata (bank_wdat[b]),
            .rdata (bank_q[b])
        );
    end

    // ---------------- read stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            pipe_valid_reg <= 1'b1;
        end
        else if (pipe_adv)
        begin
            pipe_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pipe_reg <= meta_next;
        end
    end

    always_comb
    begin
        logic [1:0] b;
        rd_next = '0;
        for (int k = 0; k < 4; k++)
        begin
            b = pipe_reg.offset + 2'(k);
            if (pipe_reg.take[k] && pipe_reg.is_read)
            begin
                rd_next[8*k +: 8] = bank_q[b];
            end
        end
        if (pipe_reg.is_read && pipe_reg.sext)
        begin
            if (pipe_reg.asize == SZ_BYTE && rd_next[7])
            begin
                rd_next[31:8] = '1;
            end
            else if (pipe_reg.asize == SZ_HALF && rd_next[15])
            begin
                rd_next[31:16] = '1;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pipe_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            read_data_reg <= rd_next;
            oor_reg       <= pipe_reg.bad;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign out_of_range = oor_reg;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench
    import lebm_pkg::*;
();

    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_WIDE = 2'd3;   // decodes as a word
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              oor;
    } access_result_t;

    // Byte-level image of the store plus the queue of results still owed.
    class lebm_scoreboard;
        bit [7:0]       store_image [CAP_BYTES];
        int unsigned    size_now;
        access_result_t expected_results [$];
        int mismatches;
        int n_reads;
        int n_writes;
        int n_oor;

        function new();
            foreach (store_image[i])
                store_image[i] = FILL_BYTE;
            size_now = SIZE_RESET;
        endfunction

        function void set_size(logic [CFG_W-1:0] v);
            int unsigned t;
            t = v;
            t = (t + 15) & 32'hFFFF_FFF0;
            if (t > CAP_BYTES)
                t = CAP_BYTES;
            size_now = t;
        endfunction

        function void note_request(logic op, logic [1:0] sz, logic sx,
                                   logic [DATA_W-1:0] addr, logic [DATA_W-1:0] wd);
            access_result_t r;
            int nbytes;
            logic [DATA_W-1:0] a;
            r = '0;
            nbytes = (sz == SZ_BYTE) ? 1 : ((sz == SZ_HALF) ? 2 : 4);
            for (int k = 0; k < nbytes; k++) begin
                a = addr + k;   // wraps past the top of the address space
                if (a >= size_now || a >= CAP_BYTES)
                    r.oor = 1'b1;
                else if (op == OP_WRITE)
                    store_image[a[ADDR_W-1:0]] = wd[8*k +: 8];
                else
                    r.data[8*k +: 8] = store_image[a[ADDR_W-1:0]];
            end
            if (op == OP_READ && sx) begin
                if (nbytes == 1 && r.data[7])
                    r.data[31:8] = '1;
                else if (nbytes == 2 && r.data[15])
                    r.data[31:16] = '1;
            end
            if (op == OP_WRITE)
                n_writes++;
            else
                n_reads++;
            if (r.oor)
                n_oor++;
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [DATA_W-1:0] rd, logic oor);
            access_result_t e;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result data %h flag %b", $time, rd, oor);
                return;
            end
            e = expected_results.pop_front();
            if (rd !== e.data || oor !== e.oor) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: expected data %h flag %b, got data %h flag %b",
                             $time, e.data, e.oor, rd, oor);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              opcode;
    logic [1:0]        access_size;
    logic              sign_extend;
    logic [DATA_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic              out_valid;
    logic              out_ready;
    logic [DATA_W-1:0] read_data;
    logic              out_of_range;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;

    lebm_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_ack;
    int hold_left;
    int size_settings;

    little_endian_byte_memory_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .access_size  (access_size),
        .sign_extend  (sign_extend),
        .address      (address),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .out_of_range (out_of_range),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request from the main flow.
    always @(posedge clk)
    begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_we)
                sb.set_size(cfg_wdata);
            if (in_valid && in_ready)
                sb.note_request(opcode, access_size, sign_extend, address, write_data);
            if (out_valid && out_ready)
                sb.check_result(read_data, out_of_range);
        end
    end

    // Leaves valid high after acceptance; the caller lowers it when done.
    task automatic issue(input logic op, input logic [1:0] sz, input logic sx,
                         input logic [DATA_W-1:0] addr, input logic [DATA_W-1:0] wd);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 12)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        access_size <= sz;
        sign_extend <= sx;
        address     <= addr;
        write_data  <= wd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_address();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return $urandom_range(63);
        else if (r < 70)
            return sb.size_now - 6 + $urandom_range(11);   // straddle the bound
        else if (r < 78)
            return CAP_BYTES - 6 + $urandom_range(11);
        else if (r < 86)
            return 32'hFFFF_FFF8 + $urandom_range(7);
        else if (r < 93 && sb.size_now > 0)
            return $urandom_range(sb.size_now - 1);
        else
            return $urandom;
    endfunction

    task automatic random_request();
        logic op;
        logic [1:0] sz;
        op = ($urandom_range(99) < 45) ? OP_WRITE : OP_READ;
        sz = $urandom_range(99) < 10 ? SZ_WIDE : 2'($urandom_range(2));
        issue(op, sz, 1'($urandom_range(1)), pick_address(), $urandom);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] v);
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        size_settings++;
    endtask

    initial
    begin
        logic [CFG_W-1:0] sizes [6];
        int guard;
        sb = new();
        sizes = '{17'd0, 17'd1, 17'h1FFFF, 17'd1000, 17'd65521, 17'($urandom)};
        hold_req = 0;
        hold_ack = 0;
        hold_left = 0;
        size_settings = 1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_READ;
        access_size = SZ_BYTE;
        sign_extend = 1'b0;
        address = '0;
        write_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset contents, sign handling, bound and wrap cases at full size
        issue(OP_READ,  SZ_BYTE, 1'b0, 32'd0, 32'd0);
        issue(OP_READ,  SZ_BYTE, 1'b1, 32'd1, 32'd0);
        issue(OP_READ,  SZ_HALF, 1'b1, 32'd2, 32'd0);
        issue(OP_READ,  SZ_WORD, 1'b0, 32'd3, 32'hFFFF_FFFF);
        issue(OP_WRITE, SZ_WORD, 1'b1, 32'd0, 32'h80FF_7F01);
        issue(OP_READ,  SZ_BYTE, 1'b1, 32'd0, 32'd0);
        issue(OP_READ,  SZ_BYTE, 1'b1, 32'd1, 32'd0);
        issue(OP_READ,  SZ_BYTE, 1'b1, 32'd2, 32'd0);
        issue(OP_READ,  SZ_HALF, 1'b1, 32'd1, 32'd0);
        issue(OP_READ,  SZ_HALF, 1'b0, 32'd2, 32'd0);
        issue(OP_READ,  SZ_WORD, 1'b1, 32'd0, 32'd0);
        issue(OP_READ,  SZ_WIDE, 1'b1, 32'd0, 32'd0);
        issue(OP_WRITE, SZ_HALF, 1'b0, 32'h0000_FFFF, 32'h0000_1234);
        issue(OP_READ,  SZ_WORD, 1'b0, 32'h0000_FFFE, 32'd0);
        issue(OP_WRITE, SZ_WORD, 1'b0, 32'hFFFF_FFFE, 32'hDEAD_BEEF);
        issue(OP_READ,  SZ_WIDE, 1'b0, 32'hFFFF_FFFF, 32'd0);
        issue(OP_WRITE, SZ_BYTE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(OP_READ,  SZ_BYTE, 1'b1, 32'h8000_0000, 32'd0);
        issue(OP_WRITE, SZ_WIDE, 1'b0, 32'd4, 32'h0000_0000);
        issue(OP_READ,  SZ_WORD, 1'b0, 32'd4, 32'd0);
        issue(OP_READ,  SZ_HALF, 1'b1, 32'd5, 32'd0);

        for (int p = 0; p < 7; p++) begin
            if (p > 0)
                write_size(sizes[p-1]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (p == 4)
                hold_req++;   // long output stall; input side keeps pushing
            repeat (62) random_request();
        end

        in_valid <= 1'b0;
        guard = 0;
        while (sb.pending() > 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);

        $display("Run covered %0d reads and %0d writes, %0d of them out of range,",
                 sb.n_reads, sb.n_writes, sb.n_oor);
        $display("across %0d size settings with mixed sender and receiver stalls.",
                 size_settings);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else begin
            if (sb.pending() > 0)
                $display("%0d expected results never arrived", sb.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
